// File: design/edf_ready_and_timer_queues_defines.svh
// ----------------------------------------------------------------------------
// EDF scheduler assertion macros
// Assertion forms used by the scheduler's queue module.
// ----------------------------------------------------------------------------
`ifndef EDF_READY_AND_TIMER_QUEUES_DEFINES_SVH
`define EDF_READY_AND_TIMER_QUEUES_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EDF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define EDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/edf_pkg.sv
// ----------------------------------------------------------------------------
// EDF scheduler package
// Sizes, codes and shared types of the scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edf_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int KEY_W     = 32;
   localparam logic [KEY_W-1:0] KEY_MAX = '1;

   typedef enum logic [2:0] {
      CMD_CREATE    = 3'd0,
      CMD_TERMINATE = 3'd1,
      CMD_SLEEP     = 3'd2,
      CMD_SET_DL    = 3'd3,
      CMD_TICK      = 3'd4,
      CMD_SET_TICK  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_IDLE_TK = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      Q_NOP,
      Q_INSERT,
      Q_POP
   } qop_type;

   typedef enum logic [1:0] {
      QS_IDLE,
      QS_INS,
      QS_POP
   } qstate_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RDY_POP,
      S_RDY_INS,
      S_SLP_INS,
      S_DRAIN_CHK,
      S_SLP_POP,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      qop_type          op;
      logic [IDX_W-1:0] slot;
      logic [KEY_W-1:0] key;
   } qcmd_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] head_slot;
      logic [KEY_W-1:0] head_key;
   } qstat_type;

endpackage

// File: design/edf_ready_and_timer_queues.sv
// ----------------------------------------------------------------------------
// EDF ready and timer queues
// Earliest-deadline-first scheduler with a deadline-sorted ready queue and a
// wake-time-sorted timer queue, driven by a command sequencer.
// ----------------------------------------------------------------------------
//   Channel   Dir   Signals                                        Handshake
//   req       in    command, task_id, value                        valid/ready
//   rsp       out   running_task, running_deadline, deadline_passed,
//                   tick_now, status                               valid/ready
//
// Each queue moves one entry at a time: an insert walks from the tail, a
// pop shifts every entry down, and a tick moves each woken sleeper, while
// the ready queue has room, back into the ready queue. Each queue has one
// comparator and one write port.
// Reset is synchronous; the idle task is in the ready queue right after it.
// req_ready is low while an item is in work; a stalled result holds in the
// output register until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edf_ready_and_timer_queues
   import edf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [3:0]  req_task_id,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_running_task,
   output logic [31:0] rsp_running_deadline,
   output logic        rsp_deadline_passed,
   output logic [31:0] rsp_tick_now,
   output logic [1:0]  rsp_status
);

   seq_state_type    state_ff, state_in;
   cmd_type          cmd_ff;
   status_type       status_ff;
   logic [IDX_W-1:0] ins_slot_ff;
   logic [KEY_W-1:0] ins_key_ff;
   logic [KEY_W-1:0] tick_ff;
   logic             sent_ff, sent_in;
   logic [KEY_W-1:0] deadline_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] used_ff;

   logic             rsp_valid_ff;
   logic [3:0]       rsp_task_ff;
   logic [KEY_W-1:0] rsp_dl_ff;
   logic             rsp_passed_ff;
   logic [KEY_W-1:0] rsp_tick_ff;
   logic [1:0]       rsp_status_ff;

   qcmd_type  rq_cmd, sq_cmd;
   qstat_type rq_stat, sq_stat;

   logic             accept;
   cmd_type          req_cmd;
   logic [IDX_W-1:0] req_slot;
   logic [IDX_W-1:0] head;
   logic             head_idle;
   logic             create_bad;
   logic             sleep_full;
   logic             drain_ok;
   logic             start;
   logic             out_load;

   edf_queue u_ready (
      .clock     (clock),
      .reset     (reset),
      .init_idle (1'b1),
      .cmd       (rq_cmd),
      .stat      (rq_stat)
   );

   edf_queue u_timer (
      .clock     (clock),
      .reset     (reset),
      .init_idle (1'b0),
      .cmd       (sq_cmd),
      .stat      (sq_stat)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign req_cmd    = cmd_type'(req_command);
   assign req_slot   = IDX_W'(req_task_id);
   assign head       = rq_stat.head_slot;
   assign head_idle  = (head == '0);
   assign create_bad = (32'(req_task_id) >= MAX_TASKS) || used_ff[req_slot] ||
                       (rq_stat.count >= CNT_W'(MAX_TASKS));
   assign sleep_full = sq_stat.count >= CNT_W'(MAX_TASKS);
   assign drain_ok   = (sq_stat.count != '0) && (sq_stat.head_key <= tick_ff) &&
                       (rq_stat.count < CNT_W'(MAX_TASKS));
   assign out_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd) inside
                  CMD_CREATE:    state_in = create_bad ? S_DONE : S_RDY_INS;
                  CMD_TERMINATE, CMD_SET_DL:
                                 state_in = head_idle ? S_DONE : S_RDY_POP;
                  CMD_SLEEP:     state_in = (head_idle || sleep_full) ? S_DONE : S_RDY_POP;
                  CMD_TICK:      state_in = S_DRAIN_CHK;
                  default:       state_in = S_DONE;
               endcase
            end
         end
         S_RDY_POP: begin
            if (rq_stat.done) begin
               if (cmd_ff == CMD_SLEEP) begin
                  state_in = S_SLP_INS;
               end else if (cmd_ff == CMD_SET_DL) begin
                  state_in = S_RDY_INS;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RDY_INS: begin
            if (rq_stat.done) begin
               state_in = (cmd_ff == CMD_TICK) ? S_DRAIN_CHK : S_DONE;
            end
         end
         S_SLP_INS: begin
            if (sq_stat.done) begin
               state_in = S_DONE;
            end
         end
         S_DRAIN_CHK: state_in = drain_ok ? S_SLP_POP : S_DONE;
         S_SLP_POP: begin
            if (sq_stat.done) begin
               state_in = S_RDY_INS;
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Queue commands; each wait state launches its operation once.
   always_comb begin
      rq_cmd.op   = Q_NOP;
      rq_cmd.slot = ins_slot_ff;
      rq_cmd.key  = ins_key_ff;
      sq_cmd.op   = Q_NOP;
      sq_cmd.slot = ins_slot_ff;
      sq_cmd.key  = ins_key_ff;
      start       = 1'b0;
      unique case (state_ff)
         S_RDY_POP: begin
            rq_cmd.op = sent_ff ? Q_NOP : Q_POP;
            start     = !sent_ff;
         end
         S_RDY_INS: begin
            rq_cmd.op = sent_ff ? Q_NOP : Q_INSERT;
            start     = !sent_ff;
         end
         S_SLP_INS: begin
            sq_cmd.op = sent_ff ? Q_NOP : Q_INSERT;
            start     = !sent_ff;
         end
         S_SLP_POP: begin
            sq_cmd.op = sent_ff ? Q_NOP : Q_POP;
            start     = !sent_ff;
         end
         default: start = 1'b0;
      endcase
   end

   assign sent_in = start ? 1'b1 : ((rq_stat.done || sq_stat.done) ? 1'b0 : sent_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sent_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         used_ff      <= MAX_TASKS'(1);
      end else begin
         state_ff <= state_in;
         sent_ff  <= sent_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && req_cmd == CMD_TICK) begin
            tick_ff <= tick_ff + 1'b1;
         end else if (accept && req_cmd == CMD_SET_TICK) begin
            tick_ff <= req_value;
         end
         if (accept && req_cmd == CMD_CREATE && !create_bad) begin
            used_ff[req_slot] <= 1'b1;
         end else if (accept && req_cmd == CMD_TERMINATE && !head_idle) begin
            used_ff[head] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         status_ff <= ST_OK;
         unique case (req_cmd)
            CMD_CREATE: begin
               ins_slot_ff <= req_slot;
               ins_key_ff  <= req_value;
               if (create_bad) begin
                  status_ff <= ST_FULL;
               end else begin
                  deadline_ff[req_slot] <= req_value;
               end
            end
            CMD_TERMINATE: begin
               if (head_idle) begin
                  status_ff <= ST_IDLE_TK;
               end
            end
            CMD_SLEEP: begin
               ins_slot_ff <= head;
               ins_key_ff  <= tick_ff + req_value;
               if (head_idle) begin
                  status_ff <= ST_IDLE_TK;
               end else if (sleep_full) begin
                  status_ff <= ST_FULL;
               end
            end
            CMD_SET_DL: begin
               ins_slot_ff <= head;
               ins_key_ff  <= req_value;
               if (head_idle) begin
                  status_ff <= ST_IDLE_TK;
               end else begin
                  deadline_ff[head] <= req_value;
               end
            end
            default: status_ff <= ST_OK;
         endcase
      end else if (state_ff == S_DRAIN_CHK && drain_ok) begin
         // The woken sleeper re-enters the ready queue under its own deadline.
         ins_slot_ff <= sq_stat.head_slot;
         ins_key_ff  <= deadline_ff[sq_stat.head_slot];
      end
      if (out_load) begin
         rsp_task_ff   <= 4'(rq_stat.head_slot);
         rsp_dl_ff     <= rq_stat.head_key;
         rsp_passed_ff <= rq_stat.head_key <= tick_ff;
         rsp_tick_ff   <= tick_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_running_task     = rsp_task_ff;
   assign rsp_running_deadline = rsp_dl_ff;
   assign rsp_deadline_passed  = rsp_passed_ff;
   assign rsp_tick_now         = rsp_tick_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

// File: design/edf_queue.sv
// ----------------------------------------------------------------------------
// EDF sorted queue
// Key-sorted slot queue; insert and pop move one entry per cycle through
// a single comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "edf_ready_and_timer_queues_defines.svh"

module edf_queue
   import edf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      init_idle,
   input  qcmd_type  cmd,
   output qstat_type stat
);

   logic [IDX_W-1:0] order_ff [MAX_TASKS];
   logic [KEY_W-1:0] keys_ff  [MAX_TASKS];
   qstate_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] slot_ff;
   logic [KEY_W-1:0] key_ff;

   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   logic [KEY_W-1:0] rd_key;
   logic [IDX_W-1:0] rd_slot;
   logic             ins_shift;
   logic             pop_move;
   logic             done;
   logic             wr_en;
   logic [KEY_W-1:0] wr_key;
   logic [IDX_W-1:0] wr_slot;

   assign rd_idx  = (state_ff == QS_INS) ? IDX_W'(idx_ff - 1'b1) : idx_ff[IDX_W-1:0];
   assign rd_key  = keys_ff[rd_idx];
   assign rd_slot = order_ff[rd_idx];

   // A new entry goes in front of every entry with an equal or greater key.
   assign ins_shift = (idx_ff != '0) && (rd_key >= key_ff);
   assign pop_move  = idx_ff < count_ff;
   assign done      = ((state_ff == QS_INS) && !ins_shift) ||
                      ((state_ff == QS_POP) && !pop_move);

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = idx_ff[IDX_W-1:0];
      wr_key  = rd_key;
      wr_slot = rd_slot;
      if (state_ff == QS_INS) begin
         wr_en = 1'b1;
         if (!ins_shift) begin
            wr_key  = key_ff;
            wr_slot = slot_ff;
         end
      end else if (state_ff == QS_POP && pop_move) begin
         wr_en  = 1'b1;
         wr_idx = IDX_W'(idx_ff - 1'b1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         QS_IDLE: begin
            if (cmd.op == Q_INSERT) begin
               state_in = QS_INS;
            end else if (cmd.op == Q_POP) begin
               state_in = QS_POP;
            end
         end
         QS_INS, QS_POP: begin
            if (done) begin
               state_in = QS_IDLE;
            end
         end
         default: state_in = QS_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (state_ff == QS_IDLE) begin
         idx_in = (cmd.op == Q_INSERT) ? count_ff : CNT_W'(1);
      end else if (state_ff == QS_INS) begin
         idx_in = idx_ff - 1'b1;
         if (!ins_shift) begin
            count_in = count_ff + 1'b1;
         end
      end else if (state_ff == QS_POP) begin
         idx_in = idx_ff + 1'b1;
         if (!pop_move) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= QS_IDLE;
         count_ff <= CNT_W'(init_idle);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (state_ff == QS_IDLE) begin
         slot_ff <= cmd.slot;
         key_ff  <= cmd.key;
      end
      if (reset && init_idle) begin
         order_ff[0] <= '0;
         keys_ff[0]  <= KEY_MAX;
      end else if (wr_en) begin
         order_ff[wr_idx] <= wr_slot;
         keys_ff[wr_idx]  <= wr_key;
      end
   end

   assign stat.done      = done;
   assign stat.count     = count_ff;
   assign stat.head_slot = order_ff[0];
   assign stat.head_key  = keys_ff[0];

   `EDF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_TASKS))
   `EDF_ASSERT_NOW(a_start_idle, clock, reset, cmd.op != Q_NOP, state_ff == QS_IDLE)
   `EDF_ASSERT_NEXT(a_ins_grow, clock, reset, done && state_ff == QS_INS,
      count_ff == $past(count_ff) + 1'b1)
   `EDF_ASSERT_NEXT(a_pop_shrink, clock, reset, done && state_ff == QS_POP,
      count_ff == $past(count_ff) - 1'b1)

endmodule

// File: dv/tb_edf_ready_and_timer_queues.sv
// ----------------------------------------------------------------------------
// EDF scheduler testbench
// Drives scheduler commands through the request channel and compares every
// response with a behavioral model of the ready and timer queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_edf_ready_and_timer_queues;
   import edf_pkg::*;

   localparam int TIMEOUT_CYCLES = 20000;

   typedef struct packed {
      logic [3:0]  task_slot;
      logic [31:0] deadline;
      logic        passed;
      logic [31:0] tick;
      logic [1:0]  status;
   } sched_view_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_command;
   logic [3:0]  req_task_id;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_running_task;
   logic [31:0] rsp_running_deadline;
   logic        rsp_deadline_passed;
   logic [31:0] rsp_tick_now;
   logic [1:0]  rsp_status;

   // Scheduler state mirrored by the predictor.
   logic [3:0]  rdy_slot[MAX_TASKS];
   logic [31:0] rdy_key[MAX_TASKS];
   int          rdy_cnt;
   logic [3:0]  slp_slot[MAX_TASKS];
   logic [31:0] slp_key[MAX_TASKS];
   int          slp_cnt;
   logic [31:0] slot_deadline[MAX_TASKS];
   logic        slot_busy[MAX_TASKS];
   logic [31:0] ticks;

   sched_view_t expected_views[$];
   int          mismatches;
   int          idle_cycles;
   bit          timed_out;
   bit          no_idle;
   bit          rsp_hold;
   int          rsp_hold_cycles;

   edf_ready_and_timer_queues dut (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Inserts in front of every entry with an equal or greater key.
   task automatic queue_insert(ref logic [3:0] slots[MAX_TASKS],
                               ref logic [31:0] keys[MAX_TASKS], ref int cnt,
                               input logic [3:0] slot, input logic [31:0] key);
      int pos;
      pos = 0;
      while (pos < cnt && keys[pos] < key) pos++;
      for (int i = cnt; i > pos; i--) begin
         slots[i] = slots[i-1];
         keys[i]  = keys[i-1];
      end
      slots[pos] = slot;
      keys[pos]  = key;
      cnt++;
   endtask

   task automatic queue_pop(ref logic [3:0] slots[MAX_TASKS],
                            ref logic [31:0] keys[MAX_TASKS], ref int cnt);
      for (int i = 1; i < cnt; i++) begin
         slots[i-1] = slots[i];
         keys[i-1]  = keys[i];
      end
      cnt--;
   endtask

   task automatic schedule_model_reset();
      for (int i = 0; i < MAX_TASKS; i++) begin
         slot_deadline[i] = '0;
         slot_busy[i]     = 1'b0;
      end
      rdy_slot[0]      = '0;
      rdy_key[0]       = KEY_MAX;
      rdy_cnt          = 1;
      slp_cnt          = 0;
      slot_deadline[0] = KEY_MAX;
      slot_busy[0]     = 1'b1;
      ticks            = '0;
   endtask

   task automatic schedule_command(input logic [2:0] cmd, input logic [3:0] id,
                                   input logic [31:0] val);
      sched_view_t v;
      logic [3:0]  head;
      logic [3:0]  s;
      status_type  st;
      head = rdy_slot[0];
      st   = ST_OK;
      case (cmd)
         CMD_CREATE: begin
            if (slot_busy[id] || rdy_cnt >= MAX_TASKS) begin
               st = ST_FULL;
            end else begin
               slot_deadline[id] = val;
               slot_busy[id]     = 1'b1;
               queue_insert(rdy_slot, rdy_key, rdy_cnt, id, val);
            end
         end
         CMD_TERMINATE: begin
            if (head == 0) begin
               st = ST_IDLE_TK;
            end else begin
               slot_busy[head] = 1'b0;
               queue_pop(rdy_slot, rdy_key, rdy_cnt);
            end
         end
         CMD_SLEEP: begin
            if (head == 0) begin
               st = ST_IDLE_TK;
            end else if (slp_cnt >= MAX_TASKS) begin
               st = ST_FULL;
            end else begin
               queue_pop(rdy_slot, rdy_key, rdy_cnt);
               queue_insert(slp_slot, slp_key, slp_cnt, head, ticks + val);
            end
         end
         CMD_SET_DL: begin
            if (head == 0) begin
               st = ST_IDLE_TK;
            end else begin
               slot_deadline[head] = val;
               queue_pop(rdy_slot, rdy_key, rdy_cnt);
               queue_insert(rdy_slot, rdy_key, rdy_cnt, head, val);
            end
         end
         CMD_TICK: begin
            ticks = ticks + 1;
            while (slp_cnt > 0 && slp_key[0] <= ticks && rdy_cnt < MAX_TASKS) begin
               s = slp_slot[0];
               queue_pop(slp_slot, slp_key, slp_cnt);
               queue_insert(rdy_slot, rdy_key, rdy_cnt, s, slot_deadline[s]);
            end
         end
         CMD_SET_TICK: ticks = val;
         default: ;
      endcase
      v.task_slot = rdy_slot[0];
      v.deadline  = rdy_key[0];
      v.passed    = (rdy_key[0] <= ticks);
      v.tick      = ticks;
      v.status    = st;
      expected_views.push_back(v);
   endtask

   // Valid stays high after an accepted item unless the sender idles, so that
   // back-to-back items never assign the valid line twice in one time step.
   task automatic send_command(input logic [2:0] cmd, input logic [3:0] id,
                               input logic [31:0] val);
      while (!no_idle && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_task_id <= id;
      req_value   <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      schedule_command(cmd, id, val);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (2 * MAX_TASKS * MAX_TASKS + 40) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return '0;
         1: return KEY_MAX;
         2: return $urandom_range(40);
         3: return ticks + $urandom_range(30);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_command(CMD_TERMINATE, 0, 0);
      send_command(CMD_SLEEP, 0, 5);
      send_command(CMD_SET_DL, 0, 7);
      send_command(CMD_CREATE, 0, 3);
      send_command(CMD_CREATE, 4'd15, 32'd100);
      send_command(CMD_CREATE, 4'd1, 32'd100);
      send_command(CMD_CREATE, 4'd1, 32'd5);
      send_command(CMD_CREATE, 4'd2, 32'd0);
      send_command(CMD_SET_DL, 0, 32'd100);
      send_command(CMD_SLEEP, 0, 32'd2);
      send_command(CMD_SLEEP, 0, 32'hFFFF_FFFF);
      send_command(CMD_TICK, 0, 0);
      send_command(CMD_TICK, 0, 0);
      send_command(CMD_SET_TICK, 0, 32'hFFFF_FFFE);
      send_command(CMD_TICK, 0, 0);
      send_command(CMD_TICK, 0, 0);
      send_command(3'd6, 4'd9, 32'h5555_AAAA);
      send_command(3'd7, 4'd6, 32'hAAAA_5555);
      send_command(CMD_TERMINATE, 0, 0);
      send_command(CMD_SET_TICK, 0, 32'd0);
   endtask

   // Fills the ready queue, sleeps every task into the timer queue, then ticks them back.
   task automatic test_full_queues();
      for (int i = 1; i < MAX_TASKS; i++) send_command(CMD_CREATE, 4'(i), 32'd50 + i);
      send_command(CMD_CREATE, 4'd3, 32'd1);
      for (int i = 0; i < MAX_TASKS + 1; i++) send_command(CMD_SLEEP, 0, 32'd1);
      for (int i = 1; i < MAX_TASKS; i++) send_command(CMD_CREATE, 4'(i), 32'd9);
      send_command(CMD_TICK, 0, 0);
      for (int i = 0; i < 2 * MAX_TASKS; i++) send_command(CMD_TERMINATE, 0, 0);
      send_command(CMD_TICK, 0, 0);
      for (int i = 0; i < 2 * MAX_TASKS; i++) send_command(CMD_TERMINATE, 0, 0);
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering items.
   task automatic test_backpressure();
      rsp_hold_cycles = 300;
      rsp_hold        = 1'b1;
      for (int i = 0; i < 8; i++) send_command(CMD_CREATE, 4'(i), $urandom);
      wait_drained();
   endtask

   task automatic test_random(input int count, input bit quiet);
      int r;
      no_idle = quiet;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 30)      send_command(CMD_CREATE, 4'($urandom), rand_value());
         else if (r < 42) send_command(CMD_TERMINATE, 4'($urandom), $urandom);
         else if (r < 56) send_command(CMD_SLEEP, 4'($urandom), $urandom_range(12));
         else if (r < 60) send_command(CMD_SLEEP, 4'($urandom), rand_value());
         else if (r < 68) send_command(CMD_SET_DL, 4'($urandom), rand_value());
         else if (r < 92) send_command(CMD_TICK, 4'($urandom), $urandom);
         else if (r < 96) send_command(CMD_SET_TICK, 4'($urandom), rand_value());
         else             send_command(3'($urandom_range(7)), 4'($urandom), $urandom);
      end
      no_idle = 1'b0;
   endtask

   // Response side: random stalls, forced hold-off and checks of each response view.
   always @(posedge clock) begin
      sched_view_t got;
      sched_view_t exp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_running_task, rsp_running_deadline, rsp_deadline_passed,
                    rsp_tick_now, rsp_status};
            if (expected_views.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               exp = expected_views.pop_front();
               if (got !== exp) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
               end
            end
         end
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
            if (rsp_hold_cycles == 0) rsp_hold = 1'b0;
            else rsp_hold_cycles--;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 22);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= TIMEOUT_CYCLES) begin
         timed_out = 1'b1;
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = '0;
      req_task_id = '0;
      req_value   = '0;
      rsp_ready   = 1'b0;
      mismatches  = 0;
      idle_cycles = 0;
      timed_out   = 1'b0;
      no_idle     = 1'b0;
      rsp_hold    = 1'b0;
      rsp_hold_cycles = 0;
      schedule_model_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_queues();
      test_backpressure();
      test_random(500, 1'b0);
      wait_drained();
      test_random(150, 1'b1);
      test_random(300, 1'b0);
      wait_drained();
      if (!timed_out && mismatches == 0 && expected_views.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
